// File: sv/acpt_pkg.sv
// ----------------------------------------------------------------------------
// acpt_pkg
// Shared types and constants of the contact pair tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package acpt_pkg;

  localparam int TYPE_W  = 3;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int MASK_W  = 64;
  localparam int EVENT_W = 2;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_t;

  typedef struct packed {
    logic active;
    logic hit;
  } pair_chk_t;

endpackage

`default_nettype wire

// File: sv/acpt_ram.sv
// ----------------------------------------------------------------------------
// acpt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/acpt_hit.sv
// ----------------------------------------------------------------------------
// acpt_hit
// Pair qualification and strict box overlap test for one registered request.
// ----------------------------------------------------------------------------
`default_nettype none

module acpt_hit
  import acpt_pkg::*;
#(
  parameter int TYPE_COUNT = 8,
  parameter int ID_BITS    = 6
) (
  input  wire logic [MASK_W-1:0]  mask,
  input  wire logic [TYPE_W-1:0]  left_type,
  input  wire logic [TYPE_W-1:0]  right_type,
  input  wire logic [ID_BITS-1:0] left_id,
  input  wire logic [ID_BITS-1:0] peer_id,
  input  wire logic [COORD_W-1:0] left_x,
  input  wire logic [COORD_W-1:0] left_y,
  input  wire logic [SIZE_W-1:0]  left_w,
  input  wire logic [SIZE_W-1:0]  left_h,
  input  wire logic [COORD_W-1:0] right_x,
  input  wire logic [COORD_W-1:0] right_y,
  input  wire logic [SIZE_W-1:0]  right_w,
  input  wire logic [SIZE_W-1:0]  right_h,
  output pair_chk_t               chk
);

  logic [TYPE_W-1:0]    lo_type;
  logic [TYPE_W-1:0]    hi_type;
  logic                 type_ok;
  logic                 enabled;
  logic [COORD_W:0]     dx;
  logic [COORD_W:0]     dy;
  logic [COORD_W:0]     adx;
  logic [COORD_W:0]     ady;
  logic [SIZE_W:0]      sum_w;
  logic [SIZE_W:0]      sum_h;

  always_comb begin
    lo_type = (left_type < right_type) ? left_type : right_type;
    hi_type = (left_type < right_type) ? right_type : left_type;
    type_ok = {1'b0, hi_type} < (TYPE_W + 1)'(TYPE_COUNT);
    enabled = type_ok && mask[{lo_type, hi_type}];

    dx  = {right_x[COORD_W-1], right_x} - {left_x[COORD_W-1], left_x};
    dy  = {right_y[COORD_W-1], right_y} - {left_y[COORD_W-1], left_y};
    adx = dx[COORD_W] ? (~dx + 1'b1) : dx;
    ady = dy[COORD_W] ? (~dy + 1'b1) : dy;

    sum_w = {1'b0, left_w} + {1'b0, right_w};
    sum_h = {1'b0, left_h} + {1'b0, right_h};

    chk.active = enabled && (left_id != peer_id);
    chk.hit    = chk.active
                 && ({adx, 1'b0} < {2'b00, sum_w})
                 && ({ady, 1'b0} < {2'b00, sum_h});
  end

endmodule

`default_nettype wire

// File: sv/aabb_contact_pair_tracker.sv
// ----------------------------------------------------------------------------
// aabb_contact_pair_tracker
// Box overlap test per collider pair with enter, stay and exit tracking.
//
//   channel  direction  handshake              payload
//   in_      input      start, busy            types, ids, centres, sizes
//   out_     output     out_valid (strobe)     contact_event, overlapping
//   cfg_     input      cfg_we                 cfg_wdata (pair enable mask)
//
// One request per cycle; busy is always low. Results pass the s1 and output registers.
// The contact bits live in a RAM of one row per left id; the read-modify-write
// of a row forwards back-to-back updates of the same row.
// Reset clears the mask and a valid bit per row, so no clearing pass is needed.
// The receiver cannot stall; each result strobes for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_contact_pair_tracker
  import acpt_pkg::*;
#(
  parameter int TYPE_COUNT = 8,
  parameter int ID_BITS    = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [TYPE_W-1:0]  in_left_type,
  input  wire logic [TYPE_W-1:0]  in_right_type,
  input  wire logic [ID_BITS-1:0] in_left_id,
  input  wire logic [ID_BITS-1:0] in_right_id,
  input  wire logic [COORD_W-1:0] in_left_x,
  input  wire logic [COORD_W-1:0] in_left_y,
  input  wire logic [SIZE_W-1:0]  in_left_w,
  input  wire logic [SIZE_W-1:0]  in_left_h,
  input  wire logic [COORD_W-1:0] in_right_x,
  input  wire logic [COORD_W-1:0] in_right_y,
  input  wire logic [SIZE_W-1:0]  in_right_w,
  input  wire logic [SIZE_W-1:0]  in_right_h,
  output logic                    out_valid,
  output logic [EVENT_W-1:0]      out_contact_event,
  output logic                    out_overlapping,
  input  wire logic               cfg_we,
  input  wire logic [MASK_W-1:0]  cfg_wdata
);

  localparam int ROWS = 1 << ID_BITS;

  logic                 accept;
  logic [MASK_W-1:0]    mask_r;

  logic                 s1_valid_r;
  logic [TYPE_W-1:0]    s1_lt_r;
  logic [TYPE_W-1:0]    s1_rt_r;
  logic [ID_BITS-1:0]   s1_lid_r;
  logic [ID_BITS-1:0]   s1_rid_r;
  logic [COORD_W-1:0]   s1_lx_r;
  logic [COORD_W-1:0]   s1_ly_r;
  logic [SIZE_W-1:0]    s1_lw_r;
  logic [SIZE_W-1:0]    s1_lh_r;
  logic [COORD_W-1:0]   s1_rx_r;
  logic [COORD_W-1:0]   s1_ry_r;
  logic [SIZE_W-1:0]    s1_rw_r;
  logic [SIZE_W-1:0]    s1_rh_r;

  pair_chk_t            chk;
  logic [ROWS-1:0]      ram_rdata;
  logic [ROWS-1:0]      row_cur;
  logic [ROWS-1:0]      row_nxt;
  logic                 prev;
  logic                 row_we;

  logic [ROWS-1:0]      row_valid_r;
  logic                 fwd_valid_r;
  logic [ID_BITS-1:0]   fwd_row_r;
  logic [ROWS-1:0]      fwd_data_r;

  logic                 out_valid_r;
  contact_event_t       event_r;
  contact_event_t       event_nxt;
  logic                 overlapping_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // hold request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mask_r     <= '0;
    end else begin
      s1_valid_r <= accept;
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lt_r  <= in_left_type;
      s1_rt_r  <= in_right_type;
      s1_lid_r <= in_left_id;
      s1_rid_r <= in_right_id;
      s1_lx_r  <= in_left_x;
      s1_ly_r  <= in_left_y;
      s1_lw_r  <= in_left_w;
      s1_lh_r  <= in_left_h;
      s1_rx_r  <= in_right_x;
      s1_ry_r  <= in_right_y;
      s1_rw_r  <= in_right_w;
      s1_rh_r  <= in_right_h;
    end
  end

  acpt_hit #(
    .TYPE_COUNT (TYPE_COUNT),
    .ID_BITS    (ID_BITS)
  ) u_hit (
    .mask       (mask_r),
    .left_type  (s1_lt_r),
    .right_type (s1_rt_r),
    .left_id    (s1_lid_r),
    .peer_id    (s1_rid_r),
    .left_x     (s1_lx_r),
    .left_y     (s1_ly_r),
    .left_w     (s1_lw_r),
    .left_h     (s1_lh_r),
    .right_x    (s1_rx_r),
    .right_y    (s1_ry_r),
    .right_w    (s1_rw_r),
    .right_h    (s1_rh_r),
    .chk        (chk)
  );

  acpt_ram #(
    .WIDTH (ROWS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (s1_lid_r),
    .wdata (row_nxt),
    .raddr (in_left_id),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (!row_valid_r[s1_lid_r]) begin
      row_cur = '0;
    end else if (fwd_valid_r && (fwd_row_r == s1_lid_r)) begin
      row_cur = fwd_data_r;
    end else begin
      row_cur = ram_rdata;
    end
    prev              = row_cur[s1_rid_r];
    row_nxt           = row_cur;
    row_nxt[s1_rid_r] = chk.hit;
    row_we            = s1_valid_r && chk.active;

    if (!chk.active) begin
      event_nxt = EV_NONE;
    end else if (chk.hit) begin
      event_nxt = prev ? EV_STAY : EV_ENTER;
    end else begin
      event_nxt = prev ? EV_EXIT : EV_NONE;
    end
  end

  // advance contact row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= row_we;
      out_valid_r <= s1_valid_r;
      if (row_we) begin
        row_valid_r[s1_lid_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      fwd_row_r  <= s1_lid_r;
      fwd_data_r <= row_nxt;
    end
    event_r       <= event_nxt;
    overlapping_r <= chk.hit;
  end

  assign out_valid         = out_valid_r;
  assign out_contact_event = event_r;
  assign out_overlapping   = overlapping_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_valid_r)
    else $error("request in flight produced no result");

  a_hit_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && overlapping_r) |-> (event_r == EV_ENTER || event_r == EV_STAY))
    else $error("overlap reported without enter or stay");

  a_miss_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !overlapping_r) |-> (event_r == EV_NONE || event_r == EV_EXIT))
    else $error("no overlap reported with enter or stay");

  a_fwd_stay: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && chk.hit ##1 s1_valid_r && chk.hit
     && s1_lid_r == $past(s1_lid_r) && s1_rid_r == $past(s1_rid_r))
    |=> (event_r == EV_STAY))
    else $error("back-to-back hit on same pair not seen as stay");

endmodule

`default_nettype wire

// File: test/tb_aabb_contact_pair_tracker.sv
// ----------------------------------------------------------------------------
// tb_aabb_contact_pair_tracker
// Self-checking bench for the box contact pair tracker. Pair requests are
// sent through the start/busy port with random gaps, each accepted request
// is run through a local contact predictor, and every strobed result is
// checked in order against the predicted event and overlap flag. Directed
// tests cover disabled and self pairs, enter/stay/exit sequences, box extremes
// and mask symmetry; random phases reuse a small id pool under several masks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aabb_contact_pair_tracker;
  import acpt_pkg::*;

  localparam int ID_W      = 6;
  localparam int NUM_TYPES = 8;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 315;

  typedef struct {
    logic [TYPE_W-1:0]         lt;
    logic [TYPE_W-1:0]         rt;
    logic [ID_W-1:0]           lid;
    logic [ID_W-1:0]           rid;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic [SIZE_W-1:0]         lw;
    logic [SIZE_W-1:0]         lh;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic [SIZE_W-1:0]         rw;
    logic [SIZE_W-1:0]         rh;
  } pair_req_t;

  typedef struct {
    contact_event_t ev;
    logic           ov;
  } contact_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [TYPE_W-1:0]  in_left_type;
  logic [TYPE_W-1:0]  in_right_type;
  logic [ID_W-1:0]    in_left_id;
  logic [ID_W-1:0]    in_right_id;
  logic [COORD_W-1:0] in_left_x;
  logic [COORD_W-1:0] in_left_y;
  logic [SIZE_W-1:0]  in_left_w;
  logic [SIZE_W-1:0]  in_left_h;
  logic [COORD_W-1:0] in_right_x;
  logic [COORD_W-1:0] in_right_y;
  logic [SIZE_W-1:0]  in_right_w;
  logic [SIZE_W-1:0]  in_right_h;
  logic               out_valid;
  logic [EVENT_W-1:0] out_contact_event;
  logic               out_overlapping;
  logic               cfg_we;
  logic [MASK_W-1:0]  cfg_wdata;

  logic [MASK_W-1:0]       pair_mask;
  bit [(1<<(2*ID_W))-1:0]  contact_bits;
  contact_result_t         pending_contacts[$];

  int  errors;
  int  requests_sent;
  int  directed_sent;
  int  mask_writes;
  int  enters_seen;
  int  stays_seen;
  int  exits_seen;
  bit  burst_mode;

  aabb_contact_pair_tracker #(
    .TYPE_COUNT(NUM_TYPES),
    .ID_BITS   (ID_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_left_type     (in_left_type),
    .in_right_type    (in_right_type),
    .in_left_id       (in_left_id),
    .in_right_id      (in_right_id),
    .in_left_x        (in_left_x),
    .in_left_y        (in_left_y),
    .in_left_w        (in_left_w),
    .in_left_h        (in_left_h),
    .in_right_x       (in_right_x),
    .in_right_y       (in_right_y),
    .in_right_w       (in_right_w),
    .in_right_h       (in_right_h),
    .out_valid        (out_valid),
    .out_contact_event(out_contact_event),
    .out_overlapping  (out_overlapping),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic contact_result_t predict_contact(pair_req_t r);
    logic [TYPE_W-1:0] lo_t;
    logic [TYPE_W-1:0] hi_t;
    int                dx;
    int                dy;
    logic              hit;
    logic              prev;
    contact_result_t   res;
    res.ev = EV_NONE;
    res.ov = 1'b0;
    lo_t = (r.lt < r.rt) ? r.lt : r.rt;
    hi_t = (r.lt < r.rt) ? r.rt : r.lt;
    if (pair_mask[{lo_t, hi_t}] && r.lid != r.rid) begin
      dx = int'(r.rx) - int'(r.lx);
      dy = int'(r.ry) - int'(r.ly);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      hit = (2 * dx < int'(r.lw) + int'(r.rw)) && (2 * dy < int'(r.lh) + int'(r.rh));
      prev = contact_bits[{r.lid, r.rid}];
      res.ov = hit;
      if (hit) begin
        res.ev = prev ? EV_STAY : EV_ENTER;
        contact_bits[{r.lid, r.rid}] = 1'b1;
      end else if (prev) begin
        res.ev = EV_EXIT;
        contact_bits[{r.lid, r.rid}] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic pair_req_t box_pair(int lt, int rt, int lid, int rid,
                                         int lx, int ly, int lw, int lh,
                                         int rx, int ry, int rw, int rh);
    pair_req_t r;
    r.lt = TYPE_W'(lt);   r.rt = TYPE_W'(rt);
    r.lid = ID_W'(lid);   r.rid = ID_W'(rid);
    r.lx = COORD_W'(lx);  r.ly = COORD_W'(ly);
    r.lw = SIZE_W'(lw);   r.lh = SIZE_W'(lh);
    r.rx = COORD_W'(rx);  r.ry = COORD_W'(ry);
    r.rw = SIZE_W'(rw);   r.rh = SIZE_W'(rh);
    return r;
  endfunction

  function automatic pair_req_t random_pair(bit noise);
    pair_req_t r;
    if (noise) begin
      r.lt  = TYPE_W'($urandom);   r.rt  = TYPE_W'($urandom);
      r.lid = ID_W'($urandom);     r.rid = ID_W'($urandom);
      r.lx  = COORD_W'($urandom);  r.ly  = COORD_W'($urandom);
      r.lw  = SIZE_W'($urandom);   r.lh  = SIZE_W'($urandom);
      r.rx  = COORD_W'($urandom);  r.ry  = COORD_W'($urandom);
      r.rw  = SIZE_W'($urandom);   r.rh  = SIZE_W'($urandom);
    end else begin
      r.lt  = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
      r.rt  = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
      r.lid = ID_W'($urandom_range(0, 7));
      r.rid = ID_W'($urandom_range(0, 7));
      r.lx  = COORD_W'($urandom);
      r.ly  = COORD_W'($urandom);
      r.rx  = r.lx + COORD_W'($urandom_range(0, 96)) - COORD_W'(48);
      r.ry  = r.ly + COORD_W'($urandom_range(0, 96)) - COORD_W'(48);
      r.lw  = SIZE_W'($urandom_range(0, 64));
      r.lh  = SIZE_W'($urandom_range(0, 64));
      r.rw  = SIZE_W'($urandom_range(0, 64));
      r.rh  = SIZE_W'($urandom_range(0, 64));
    end
    return r;
  endfunction

  function automatic int next_gap();
    return burst_mode ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_pair(input pair_req_t r, input int gap);
    int i;
    for (i = 0; i < gap; i++) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start         = 1'b1;
    in_left_type  = r.lt;
    in_right_type = r.rt;
    in_left_id    = r.lid;
    in_right_id   = r.rid;
    in_left_x     = r.lx;
    in_left_y     = r.ly;
    in_left_w     = r.lw;
    in_left_h     = r.lh;
    in_right_x    = r.rx;
    in_right_y    = r.ry;
    in_right_w    = r.rw;
    in_right_h    = r.rh;
    do @(posedge clk); while (busy);
    pending_contacts.push_back(predict_contact(r));
    requests_sent++;
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pair_mask(input logic [MASK_W-1:0] m);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we    = 1'b0;
    pair_mask = m;
    mask_writes++;
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= 10)
      $display("mismatch %0s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  always @(posedge clk) begin
    contact_result_t exp_res;
    if (rst_n && out_valid) begin
      case (out_contact_event)
        EV_ENTER: enters_seen++;
        EV_STAY:  stays_seen++;
        EV_EXIT:  exits_seen++;
        default: ;
      endcase
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        exp_res = pending_contacts.pop_front();
        if (out_contact_event !== exp_res.ev)
          report_mismatch("contact_event", exp_res.ev, out_contact_event);
        if (out_overlapping !== exp_res.ov)
          report_mismatch("overlapping", exp_res.ov, out_overlapping);
      end
    end
  end

  task automatic test_reset_disabled();
    send_pair(box_pair(0, 0, 1, 2, 0, 0, 10, 10, 0, 0, 10, 10), 0);
    send_pair(box_pair(7, 3, 9, 4, 5, 5, 20, 20, 6, 6, 20, 20), 2);
  endtask

  task automatic test_self_pair();
    write_pair_mask('1);
    send_pair(box_pair(2, 2, 5, 5, 0, 0, 30, 30, 0, 0, 30, 30), 0);
    send_pair(box_pair(0, 7, 0, 0, 1, 1, 8, 8, 2, 2, 8, 8), 0);
  endtask

  task automatic test_contact_sequence();
    send_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 3, 3, 10, 10), 0);
    send_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 4, 4, 10, 10), 0);
    send_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 40, 0, 10, 10), 0);
    send_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 40, 0, 10, 10), 1);
    send_pair(box_pair(2, 1, 2, 1, 0, 0, 10, 10, 1, 1, 10, 10), 3);
    send_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 1, 1, 10, 10), 0);
  endtask

  task automatic test_box_extremes();
    send_pair(box_pair(7, 0, 0, 63, -32768, -32768, 32767, 32767,
                       32767, 32767, 32767, 32767), 0);
    send_pair(box_pair(0, 0, 10, 11, 0, 0, 10, 10, 10, 0, 10, 10), 0);
    send_pair(box_pair(0, 0, 10, 11, 0, 0, 11, 10, 10, 0, 10, 10), 0);
    send_pair(box_pair(7, 7, 63, 0, 100, 100, 0, 0, 100, 100, 0, 0), 1);
    send_pair(box_pair(7, 7, 63, 0, 100, 100, 1, 1, 100, 100, 0, 0), 0);
    send_pair(box_pair(3, 6, 20, 21, 32767, -32768, 32767, 4, 32767, 32767, 32767, 4), 0);
  endtask

  task automatic test_mask_symmetry();
    write_pair_mask(64'd1 << (3 * 8 + 5));
    send_pair(box_pair(5, 3, 30, 31, 0, 0, 16, 16, 2, 2, 16, 16), 0);
    send_pair(box_pair(3, 5, 32, 33, 0, 0, 16, 16, 2, 2, 16, 16), 0);
    send_pair(box_pair(3, 4, 34, 35, 0, 0, 16, 16, 2, 2, 16, 16), 0);
    write_pair_mask('0);
    send_pair(box_pair(5, 3, 30, 31, 0, 0, 16, 16, 500, 2, 16, 16), 0);
    write_pair_mask(64'd1 << (3 * 8 + 5));
    send_pair(box_pair(5, 3, 30, 31, 0, 0, 16, 16, 1, 1, 16, 16), 0);
  endtask

  task automatic test_random_traffic();
    int                phase;
    int                n;
    logic [MASK_W-1:0] m;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       m = '1;
        1:       m = {$urandom, $urandom};
        2:       m = 64'h5555_AAAA_5555_AAAA;
        3:       m = 64'hAAAA_5555_AAAA_5555;
        4:       m = {$urandom, $urandom} | {$urandom, $urandom};
        default: m = '1;
      endcase
      write_pair_mask(m);
      for (n = 0; n < PHASE_LEN; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        send_pair(random_pair($urandom_range(0, 7) == 0), next_gap());
      end
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_left_type  = '0;
    in_right_type = '0;
    in_left_id    = '0;
    in_right_id   = '0;
    in_left_x     = '0;
    in_left_y     = '0;
    in_left_w     = '0;
    in_left_h     = '0;
    in_right_x    = '0;
    in_right_y    = '0;
    in_right_w    = '0;
    in_right_h    = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    pair_mask     = '0;
    contact_bits  = '0;
    errors        = 0;
    requests_sent = 0;
    mask_writes   = 0;
    enters_seen   = 0;
    stays_seen    = 0;
    exits_seen    = 0;
    burst_mode    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_disabled();
    test_self_pair();
    test_contact_sequence();
    test_box_extremes();
    test_mask_symmetry();
    directed_sent = requests_sent;
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d pair requests (%0d directed) under %0d mask writes.",
             requests_sent, directed_sent, mask_writes);
    $display("Observed %0d enter, %0d stay and %0d exit events; %0d mismatches.",
             enters_seen, stays_seen, exits_seen, errors);
    if (errors == 0 && pending_contacts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(4 * 400000);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
